>>> hw/rtl/rmig_pkg.sv
// ----------------------------------------------------------------------------
// rmig_pkg: shared types and constants of the revolved mesh index generator
// Field widths, config register indexes and the command word that the front
// end hands to the index sequencer.
// ----------------------------------------------------------------------------
package rmig_pkg;

    // Mesh size limits
    localparam int MAX_SLICES      = 256;
    localparam int MAX_PATH_POINTS = 8;
    localparam int MIN_SLICES      = 3;
    localparam int MIN_PATH_POINTS = 2;

    // Field widths
    localparam int SLICE_W = 8;
    localparam int VBASE_W = 24;
    localparam int SLOT_W  = 14;
    localparam int VIDX_W  = 25;
    localparam int SCNT_W  = 9;
    localparam int PP_W    = 4;
    localparam int CFG_W   = 9;
    localparam int CIDX_W  = 2;

    // Vertex offset from vertex_base: up to P*S plus one
    localparam int OFS_W = $clog2(MAX_SLICES * MAX_PATH_POINTS + 2);
    // Segment counter, holds 0 .. MAX_PATH_POINTS-1
    localparam int J_W   = $clog2(MAX_PATH_POINTS);
    // Word counter inside one quad or one cap triangle
    localparam int K_W   = 3;

    // Words per quad and per cap triangle
    localparam int QUAD_WORDS = 6;
    localparam int TRI_WORDS  = 3;

    // Command queue depth
    localparam int Q_DEPTH = 2;

    // Config register indexes
    localparam logic [CIDX_W-1:0] CFG_SLICE_COUNT = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_PATH_POINTS = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_BASE_CAPPED = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_TOP_CAPPED  = 2'd3;

    // One slice, fully decoded by the front end
    typedef struct packed {
        logic [VBASE_W-1:0] vbase;
        logic [OFS_W-1:0]   pi;        // P * slice
        logic [OFS_W-1:0]   pnx;       // P * next slice
        logic [OFS_W-1:0]   ps;        // P * S, base centre vertex
        logic [J_W-1:0]     pm1;       // P - 1, segment count
        logic [SLOT_W-1:0]  slot0;     // first quad slot
        logic [SLOT_W-1:0]  slot_base; // base cap slot
        logic [SLOT_W-1:0]  slot_top;  // top cap slot
        logic               base_capped;
        logic               top_capped;
    } t_cmd;

endpackage

>>> hw/rtl/revolved_mesh_index_generator_core.sv
// ----------------------------------------------------------------------------
// revolved_mesh_index_generator_core: triangle indices for a swept mesh
// Takes one slice number and vertex base per input word and emits the index
// words of that slice's quads and optional cap triangles.
// ----------------------------------------------------------------------------
// Each accepted input word names one slice of a mesh swept around an axis.
// The block returns one output word per triangle index: 6*(P-1) quad indices,
// then 3 for the base cap and 3 for the top cap when enabled, where P is the
// clamped path point count (2..8) and S the clamped slice count (3..256).
// The final word of a slice carries o_last. A slice number not below S is
// taken and dropped with no output. Output runs at one word per cycle while
// i_stall is low, and a slice has 6*(P-1) + 3*base_capped + 3*top_capped
// words (6 to 48), issued by the index sequencer through its single output
// register. Input words are decoded at once into a two-entry command queue,
// so the input side keeps accepting while the output is stalled, until the
// queue fills; back-to-back slices stream with no gap on the output.
// Configuration (index 0 slice_count, 1 path_points, 2 base_capped,
// 3 top_capped) is written through i_cfg_we / i_cfg_index / i_cfg_data and
// must only change while the block is idle.
// ----------------------------------------------------------------------------
module revolved_mesh_index_generator_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config write port
    input  logic                          i_cfg_we,
    input  logic [rmig_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic [rmig_pkg::CFG_W-1:0]    i_cfg_data,
    // slice input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [rmig_pkg::SLICE_W-1:0]  i_slice,
    input  logic [rmig_pkg::VBASE_W-1:0]  i_vertex_base,
    // index output channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [rmig_pkg::SLOT_W-1:0]   o_slot,
    output logic [rmig_pkg::VIDX_W-1:0]   o_vertex_index,
    output logic                          o_last
);
    import rmig_pkg::*;

    // front end to queue
    logic push;
    logic q_full;
    t_cmd push_cmd;

    // queue to sequencer
    logic q_valid;
    t_cmd q_cmd;
    logic pop;

    // Slice decode: clamps config, computes all slot and vertex offsets
    rmig_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .i_slice       (i_slice),
        .i_vertex_base (i_vertex_base),
        .o_stall       (o_stall),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    // Decouples decode from the output side
    rmig_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_cmd),
        .i_pop   (pop)
    );

    // Steps through the words of one slice; next command loads on the
    // cycle that emits the current one's last word
    rmig_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_cmd        (q_cmd),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_slot         (o_slot),
        .o_vertex_index (o_vertex_index),
        .o_last         (o_last)
    );

    // Decode never writes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_full)
        else $error("command queue overflow");

    // Sequencer only takes a command that is there
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_valid)
        else $error("command queue underflow");

    // A slice's words come without a gap once the first is taken
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last) |=> o_valid)
        else $error("gap inside a slice's index words");

endmodule

>>> hw/rtl/rmig_front.sv
// ----------------------------------------------------------------------------
// rmig_front: config registers and slice decode
// Holds the config, clamps it, drops out-of-range slices and builds the
// command word for one slice.
// ----------------------------------------------------------------------------
module rmig_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rmig_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic [rmig_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_valid,
    input  logic [rmig_pkg::SLICE_W-1:0]  i_slice,
    input  logic [rmig_pkg::VBASE_W-1:0]  i_vertex_base,
    output logic                          o_stall,
    input  logic                          i_q_full,
    output logic                          o_push,
    output rmig_pkg::t_cmd                o_cmd
);
    import rmig_pkg::*;

    logic [SCNT_W-1:0]  r_slice_count;
    logic [PP_W-1:0]    r_path_points;
    logic               r_base_capped;
    logic               r_top_capped;

    logic [SCNT_W-1:0]  s_eff;
    logic [PP_W-1:0]    p_eff;
    logic [SCNT_W-1:0]  slice_inc;
    logic [SLICE_W-1:0] nx;
    logic               drop;
    logic [J_W-1:0]     pm1;
    logic [SLOT_W-1:0]  quads;
    logic [SLOT_W-1:0]  i3;
    logic [SLOT_W-1:0]  s3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice_count <= SCNT_W'(8);
            r_path_points <= PP_W'(2);
            r_base_capped <= 1'b0;
            r_top_capped  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SLICE_COUNT: r_slice_count <= i_cfg_data[SCNT_W-1:0];
                CFG_PATH_POINTS: r_path_points <= i_cfg_data[PP_W-1:0];
                CFG_BASE_CAPPED: r_base_capped <= i_cfg_data[0];
                CFG_TOP_CAPPED:  r_top_capped  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_slice_count < SCNT_W'(MIN_SLICES)) begin
            s_eff = SCNT_W'(MIN_SLICES);
        end else if (r_slice_count > SCNT_W'(MAX_SLICES)) begin
            s_eff = SCNT_W'(MAX_SLICES);
        end else begin
            s_eff = r_slice_count;
        end
        if (r_path_points < PP_W'(MIN_PATH_POINTS)) begin
            p_eff = PP_W'(MIN_PATH_POINTS);
        end else if (r_path_points > PP_W'(MAX_PATH_POINTS)) begin
            p_eff = PP_W'(MAX_PATH_POINTS);
        end else begin
            p_eff = r_path_points;
        end
    end

    assign drop      = SCNT_W'(i_slice) >= s_eff;
    assign slice_inc = SCNT_W'(i_slice) + SCNT_W'(1);
    // last slice wraps to slice 0
    assign nx        = (slice_inc == s_eff) ? '0 : slice_inc[SLICE_W-1:0];
    assign pm1       = J_W'(p_eff - PP_W'(1));

    assign quads = SLOT_W'(QUAD_WORDS) * (SLOT_W'(pm1) * SLOT_W'(s_eff));
    assign i3    = SLOT_W'(TRI_WORDS) * SLOT_W'(i_slice);
    assign s3    = SLOT_W'(TRI_WORDS) * SLOT_W'(s_eff);

    always_comb begin
        o_cmd.vbase       = i_vertex_base;
        o_cmd.pi          = OFS_W'(p_eff) * OFS_W'(i_slice);
        o_cmd.pnx         = OFS_W'(p_eff) * OFS_W'(nx);
        o_cmd.ps          = OFS_W'(p_eff) * OFS_W'(s_eff);
        o_cmd.pm1         = pm1;
        o_cmd.slot0       = SLOT_W'(QUAD_WORDS) * (SLOT_W'(pm1) * SLOT_W'(i_slice));
        o_cmd.slot_base   = quads + i3;
        o_cmd.slot_top    = quads + (r_base_capped ? s3 : '0) + i3;
        o_cmd.base_capped = r_base_capped;
        o_cmd.top_capped  = r_top_capped;
    end

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full && !drop;

endmodule

>>> hw/rtl/rmig_fifo.sv
// ----------------------------------------------------------------------------
// rmig_fifo: command queue
// Short register queue between slice decode and the index sequencer.
// ----------------------------------------------------------------------------
module rmig_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rmig_pkg::t_cmd i_data,
    output logic           o_full,
    output logic           o_valid,
    output rmig_pkg::t_cmd o_data,
    input  logic           i_pop
);
    import rmig_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_cmd             r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic push_ok;
    logic pop_ok;

    assign o_full  = r_count == CNT_W'(Q_DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        ptr_next = (p == PTR_W'(Q_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (pop_ok) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> hw/rtl/rmig_back.sv
// ----------------------------------------------------------------------------
// rmig_back: index sequencer
// Walks quads, then base cap, then top cap (caps when enabled) of one slice
// command, one index word per cycle unless stalled, into an output register.
// ----------------------------------------------------------------------------
module rmig_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    input  rmig_pkg::t_cmd               i_q_cmd,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [rmig_pkg::SLOT_W-1:0]  o_slot,
    output logic [rmig_pkg::VIDX_W-1:0]  o_vertex_index,
    output logic                         o_last
);
    import rmig_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_QUAD,
        PH_BASE,
        PH_TOP
    } t_phase;

    t_phase            r_phase;
    t_cmd              r_cmd;
    logic [J_W-1:0]    r_j;
    logic [K_W-1:0]    r_k;
    logic [SLOT_W-1:0] r_slot;
    logic              r_out_valid;
    logic [SLOT_W-1:0] r_out_slot;
    logic [VIDX_W-1:0] r_out_vidx;
    logic              r_out_last;

    logic              adv;
    logic              emit;
    logic              quad_end;
    logic              word_last;
    logic              load;
    logic [OFS_W-1:0]  pij;
    logic [OFS_W-1:0]  pnj;
    logic [OFS_W-1:0]  ofs;
    logic [VIDX_W-1:0] vidx;

    assign adv  = !r_out_valid || !i_stall;
    assign emit = (r_phase != PH_IDLE) && adv;

    assign pij = r_cmd.pi + OFS_W'(r_j);
    assign pnj = r_cmd.pnx + OFS_W'(r_j);

    assign quad_end = (r_k == K_W'(QUAD_WORDS - 1)) && (J_W'(r_j + J_W'(1)) == r_cmd.pm1);

    always_comb begin
        ofs       = pij;
        word_last = 1'b0;
        case (r_phase)
            PH_QUAD: begin
                word_last = quad_end && !r_cmd.base_capped && !r_cmd.top_capped;
                case (r_k)
                    K_W'(0): ofs = pij;
                    K_W'(1): ofs = pnj;
                    K_W'(2): ofs = pij + OFS_W'(1);
                    K_W'(3): ofs = pnj;
                    K_W'(4): ofs = pnj + OFS_W'(1);
                    default: ofs = pij + OFS_W'(1);
                endcase
            end
            PH_BASE: begin
                word_last = (r_k == K_W'(TRI_WORDS - 1)) && !r_cmd.top_capped;
                case (r_k)
                    K_W'(0): ofs = r_cmd.ps;
                    K_W'(1): ofs = r_cmd.pnx;
                    default: ofs = r_cmd.pi;
                endcase
            end
            PH_TOP: begin
                word_last = r_k == K_W'(TRI_WORDS - 1);
                case (r_k)
                    K_W'(0): ofs = r_cmd.ps + OFS_W'(r_cmd.base_capped);
                    K_W'(1): ofs = r_cmd.pi + OFS_W'(r_cmd.pm1);
                    default: ofs = r_cmd.pnx + OFS_W'(r_cmd.pm1);
                endcase
            end
            default: ;
        endcase
    end

    assign vidx = VIDX_W'(r_cmd.vbase) + VIDX_W'(ofs);
    assign load = i_q_valid && ((r_phase == PH_IDLE) || (emit && word_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_j         <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_out_valid <= emit;
            end
            if (load) begin
                r_phase <= PH_QUAD;
                r_cmd   <= i_q_cmd;
                r_j     <= '0;
                r_k     <= '0;
                r_slot  <= i_q_cmd.slot0;
            end else if (emit) begin
                if (word_last) begin
                    r_phase <= PH_IDLE;
                end else begin
                    case (r_phase)
                        PH_QUAD: begin
                            r_slot <= r_slot + SLOT_W'(1);
                            if (r_k == K_W'(QUAD_WORDS - 1)) begin
                                r_k <= '0;
                                if (quad_end) begin
                                    r_phase <= r_cmd.base_capped ? PH_BASE : PH_TOP;
                                    r_slot  <= r_cmd.base_capped ? r_cmd.slot_base
                                                                 : r_cmd.slot_top;
                                end else begin
                                    r_j <= r_j + J_W'(1);
                                end
                            end else begin
                                r_k <= r_k + K_W'(1);
                            end
                        end
                        PH_BASE: begin
                            if (r_k == K_W'(TRI_WORDS - 1)) begin
                                r_phase <= PH_TOP;
                                r_k     <= '0;
                                r_slot  <= r_cmd.slot_top;
                            end else begin
                                r_k    <= r_k + K_W'(1);
                                r_slot <= r_slot + SLOT_W'(1);
                            end
                        end
                        default: begin
                            r_k    <= r_k + K_W'(1);
                            r_slot <= r_slot + SLOT_W'(1);
                        end
                    endcase
                end
            end
            if (emit) begin
                r_out_slot <= r_slot;
                r_out_vidx <= vidx;
                r_out_last <= word_last;
            end
        end
    end

    assign o_pop          = load;
    assign o_valid        = r_out_valid;
    assign o_slot         = r_out_slot;
    assign o_vertex_index = r_out_vidx;
    assign o_last         = r_out_last;

endmodule
